// File: src/lhrs_pkg.sv
// Shared definitions for the LED heartbeat ramp sequencer.
// Holds the field widths, the register indexes, the divider sizes and the microcode ROM.
// Used by lhrs_div and led_heartbeat_ramp_sequencer_core; depends on nothing.
package lhrs_pkg;

	localparam int LEVEL_W = 8;
	localparam int PERIOD_W = 8;
	localparam int TICKS_W = 16;
	localparam int HOLD_W = 9;

	// Half the milliseconds in one second. A whole beat is always an even tick count.
	localparam int HALF_MS_PER_SECOND = 500;

	// The dividend is half the beat length in ticks, at most 500 * 255.
	localparam int DIV_W = 17;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_PEAK_LEVEL = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_LEVEL = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_SECONDS = 2'd2;

	localparam int UPC_W = 4;
	localparam logic [UPC_W-1:0] UA_FETCH = 4'd0;
	localparam logic [UPC_W-1:0] UA_TEST_HELD = 4'd1;
	localparam logic [UPC_W-1:0] UA_TEST_FLAT = 4'd2;
	localparam logic [UPC_W-1:0] UA_TEST_START = 4'd3;
	localparam logic [UPC_W-1:0] UA_DIV_START = 4'd4;
	localparam logic [UPC_W-1:0] UA_DIV_WAIT = 4'd5;
	localparam logic [UPC_W-1:0] UA_BEAT_SET = 4'd6;
	localparam logic [UPC_W-1:0] UA_TICK = 4'd7;
	localparam logic [UPC_W-1:0] UA_HELD = 4'd8;
	localparam logic [UPC_W-1:0] UA_FLAT = 4'd9;
	localparam logic [UPC_W-1:0] UA_EMIT = 4'd10;
	localparam logic [UPC_W-1:0] UA_RETURN = 4'd11;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_FETCH,
		OP_DIV_START,
		OP_BEAT_SET,
		OP_TICK,
		OP_HELD,
		OP_FLAT,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_INPUT,
		COND_HELD,
		COND_FLAT,
		COND_NOT_START,
		COND_DIV_BUSY,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t op;
		cond_t cond;
		logic [UPC_W-1:0] target;
	} ucode_t;

	// When the condition is true the sequencer jumps to the target, otherwise it steps on.
	function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] pc);
		ucode_t w;
		case (pc)
			UA_FETCH: w = '{OP_FETCH, COND_NO_INPUT, UA_FETCH};
			UA_TEST_HELD: w = '{OP_NOP, COND_HELD, UA_HELD};
			UA_TEST_FLAT: w = '{OP_NOP, COND_FLAT, UA_FLAT};
			UA_TEST_START: w = '{OP_NOP, COND_NOT_START, UA_TICK};
			UA_DIV_START: w = '{OP_DIV_START, COND_NEVER, UA_FETCH};
			UA_DIV_WAIT: w = '{OP_NOP, COND_DIV_BUSY, UA_DIV_WAIT};
			UA_BEAT_SET: w = '{OP_BEAT_SET, COND_NEVER, UA_FETCH};
			UA_TICK: w = '{OP_TICK, COND_ALWAYS, UA_EMIT};
			UA_HELD: w = '{OP_HELD, COND_ALWAYS, UA_EMIT};
			UA_FLAT: w = '{OP_FLAT, COND_NEVER, UA_FETCH};
			UA_EMIT: w = '{OP_EMIT, COND_OUT_BUSY, UA_EMIT};
			UA_RETURN: w = '{OP_NOP, COND_ALWAYS, UA_FETCH};
			default: w = '{OP_NOP, COND_ALWAYS, UA_FETCH};
		endcase
		return w;
	endfunction

endpackage

// File: src/lhrs_div.sv
// Restoring divider, one quotient bit per clock, for the beat-start step time.
// Divides a DIV_W-bit dividend by a level-wide divisor; busy falls when results are ready.
// Depends on lhrs_pkg.
module lhrs_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [lhrs_pkg::DIV_W-1:0] dividend,
	input logic [lhrs_pkg::LEVEL_W-1:0] divisor,
	output logic busy,
	output logic [lhrs_pkg::DIV_W-1:0] quotient,
	output logic [lhrs_pkg::LEVEL_W-1:0] remainder
);

	logic [lhrs_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [lhrs_pkg::LEVEL_W-1:0] rem_q;
	logic [lhrs_pkg::DIV_W-1:0] quo_q;
	logic [lhrs_pkg::LEVEL_W:0] trial;
	logic [lhrs_pkg::LEVEL_W:0] divisor_ext;
	logic fits;

	assign trial = {rem_q, quo_q[lhrs_pkg::DIV_W-1]};
	assign divisor_ext = {1'b0, divisor};
	assign fits = (trial >= divisor_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= lhrs_pkg::DIV_CNT_W'(lhrs_pkg::DIV_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= lhrs_pkg::LEVEL_W'(trial - divisor_ext);
			end else begin
				rem_q <= trial[lhrs_pkg::LEVEL_W-1:0];
			end
			quo_q <= {quo_q[lhrs_pkg::DIV_W-2:0], fits};
		end
	end

	assign busy = (cnt_q != '0);
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule

// File: src/led_heartbeat_ramp_sequencer_core.sv
// Top level of the LED heartbeat ramp sequencer: one brightness result per millisecond tick.
// A microcode ROM steps a small datapath; the step time is found by the serial divider.
// Depends on lhrs_pkg and lhrs_div.

// Each input transfer is one millisecond tick and yields exactly one result transfer with the
// level to drive and a flag on the last tick of a finished beat. Items are handled one at a
// time by a microcoded sequencer: an ordinary tick runs the fetch, test, tick, emit and return
// steps, and the first tick of a beat also starts the divider and waits for it, because the step
// time (500 * period) / (peak - min) comes from a restoring divider that yields one quotient bit
// per cycle. A finished result waits in the output register while the next tick is already taken
// in; the sequencer only pauses at its emit step if that register is still full and stalled.
// Configuration writes take effect at once and should be made while no tick is in work.
module led_heartbeat_ramp_sequencer_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [lhrs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [lhrs_pkg::LEVEL_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic button_held,
	output logic out_valid,
	input logic out_stall,
	output logic [lhrs_pkg::LEVEL_W-1:0] light_level,
	output logic beat_end
);

	typedef enum logic [1:0] {
		PH_START,
		PH_RISE,
		PH_HOLD,
		PH_FALL
	} phase_t;

	lhrs_pkg::ucode_t uw;
	logic [lhrs_pkg::UPC_W-1:0] pc_q;
	logic jump;

	logic [lhrs_pkg::LEVEL_W-1:0] peak_q;
	logic [lhrs_pkg::LEVEL_W-1:0] min_q;
	logic [lhrs_pkg::PERIOD_W-1:0] period_q;

	logic held_q;
	phase_t phase_q;
	logic [lhrs_pkg::LEVEL_W-1:0] level_q;
	logic [lhrs_pkg::TICKS_W-1:0] count_q;
	logic [lhrs_pkg::TICKS_W-1:0] step_ticks_q;
	logic [lhrs_pkg::HOLD_W-1:0] hold_ticks_q;

	logic [lhrs_pkg::LEVEL_W-1:0] res_level_q;
	logic res_end_q;
	logic out_valid_q;
	logic [lhrs_pkg::LEVEL_W-1:0] light_level_q;
	logic beat_end_q;

	logic div_start;
	logic div_busy;
	logic [lhrs_pkg::DIV_W-1:0] div_dividend;
	logic [lhrs_pkg::LEVEL_W-1:0] div_divisor;
	logic [lhrs_pkg::DIV_W-1:0] div_quotient;
	logic [lhrs_pkg::LEVEL_W-1:0] div_remainder;

	logic [lhrs_pkg::LEVEL_W:0] peak_ext;
	logic [lhrs_pkg::LEVEL_W:0] level_ext;
	logic [lhrs_pkg::LEVEL_W:0] level_inc;
	logic [lhrs_pkg::LEVEL_W:0] min_inc;
	logic flat;
	logic [lhrs_pkg::TICKS_W-1:0] count_dec;
	logic [lhrs_pkg::TICKS_W-1:0] step_eff;
	logic out_load;

	assign uw = lhrs_pkg::ucode_rom(pc_q);

	assign peak_ext = {1'b0, peak_q};
	assign level_ext = {1'b0, level_q};
	assign level_inc = level_ext + 1'b1;
	assign min_inc = {1'b0, min_q} + 1'b1;
	assign flat = (peak_ext <= min_inc);
	assign count_dec = (count_q != '0) ? count_q - 1'b1 : '0;
	assign step_eff = (div_quotient[lhrs_pkg::TICKS_W-1:0] == '0) ?
		lhrs_pkg::TICKS_W'(1) : div_quotient[lhrs_pkg::TICKS_W-1:0];

	assign div_start = (uw.op == lhrs_pkg::OP_DIV_START);
	assign div_dividend = lhrs_pkg::DIV_W'(lhrs_pkg::HALF_MS_PER_SECOND) *
		lhrs_pkg::DIV_W'(period_q);
	assign div_divisor = peak_q - min_q;

	assign out_load = (uw.op == lhrs_pkg::OP_EMIT) && (!out_valid_q || !out_stall);

	always_comb begin
		case (uw.cond)
			lhrs_pkg::COND_NEVER: jump = 1'b0;
			lhrs_pkg::COND_ALWAYS: jump = 1'b1;
			lhrs_pkg::COND_NO_INPUT: jump = !in_valid;
			lhrs_pkg::COND_HELD: jump = held_q;
			lhrs_pkg::COND_FLAT: jump = flat;
			lhrs_pkg::COND_NOT_START: jump = (phase_q != PH_START);
			lhrs_pkg::COND_DIV_BUSY: jump = div_busy;
			lhrs_pkg::COND_OUT_BUSY: jump = out_valid_q && out_stall;
			default: jump = 1'b0;
		endcase
	end

	lhrs_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.busy(div_busy),
		.quotient(div_quotient),
		.remainder(div_remainder)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= lhrs_pkg::UA_FETCH;
			peak_q <= 8'd50;
			min_q <= 8'd0;
			period_q <= 8'd2;
			held_q <= 1'b0;
			phase_q <= PH_START;
			level_q <= '0;
			count_q <= '0;
			step_ticks_q <= '0;
			hold_ticks_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= jump ? uw.target : pc_q + 1'b1;

			if (cfg_wr_en) begin
				case (cfg_index)
					lhrs_pkg::REG_PEAK_LEVEL: peak_q <= cfg_data;
					lhrs_pkg::REG_MIN_LEVEL: min_q <= cfg_data;
					lhrs_pkg::REG_PERIOD_SECONDS: period_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (uw.op)
				lhrs_pkg::OP_FETCH: begin
					held_q <= button_held;
				end
				lhrs_pkg::OP_BEAT_SET: begin
					step_ticks_q <= step_eff;
					hold_ticks_q <= {div_remainder, 1'b0};
					level_q <= min_q;
					count_q <= step_eff;
					phase_q <= PH_RISE;
				end
				lhrs_pkg::OP_TICK: begin
					count_q <= count_dec;
					if (count_dec == '0) begin
						case (phase_q)
							PH_RISE: begin
								if (level_inc >= peak_ext) begin
									level_q <= peak_q;
									if (hold_ticks_q != '0) begin
										phase_q <= PH_HOLD;
										count_q <= lhrs_pkg::TICKS_W'(hold_ticks_q);
									end else begin
										phase_q <= PH_FALL;
										count_q <= step_ticks_q;
									end
								end else begin
									level_q <= level_inc[lhrs_pkg::LEVEL_W-1:0];
									count_q <= step_ticks_q;
								end
							end
							PH_HOLD: begin
								level_q <= peak_q;
								phase_q <= PH_FALL;
								count_q <= step_ticks_q;
							end
							default: begin
								if (level_ext <= min_inc) begin
									level_q <= min_q;
									phase_q <= PH_START;
								end else begin
									level_q <= level_q - 1'b1;
									count_q <= step_ticks_q;
								end
							end
						endcase
					end
				end
				lhrs_pkg::OP_HELD: begin
					phase_q <= PH_START;
					level_q <= min_q;
				end
				lhrs_pkg::OP_FLAT: begin
					phase_q <= PH_START;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (uw.op)
			lhrs_pkg::OP_TICK: begin
				res_level_q <= level_q;
				res_end_q <= (count_dec == '0) && (phase_q != PH_RISE) &&
					(phase_q != PH_HOLD) && (level_ext <= min_inc);
			end
			lhrs_pkg::OP_HELD: begin
				res_level_q <= min_q;
				res_end_q <= 1'b0;
			end
			lhrs_pkg::OP_FLAT: begin
				res_level_q <= peak_q;
				res_end_q <= 1'b0;
			end
			default: ;
		endcase
		if (out_load) begin
			light_level_q <= res_level_q;
			beat_end_q <= res_end_q;
		end
	end

	assign in_stall = (uw.op != lhrs_pkg::OP_FETCH);
	assign out_valid = out_valid_q;
	assign light_level = light_level_q;
	assign beat_end = beat_end_q;

`ifndef SYNTHESIS
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> div_busy)
		else $error("divider did not start");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(uw.op == lhrs_pkg::OP_EMIT))
		else $error("result appeared outside the emit step");

	a_step_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_START) |-> (step_ticks_q != '0))
		else $error("zero step time inside a beat");

	a_hold_even: assert property (@(posedge clk) disable iff (!arst_n)
		hold_ticks_q[0] == 1'b0)
		else $error("odd peak hold time");
`endif

endmodule
